// ===== src/vir_pkg.sv =====
package vir_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int RES_IDX_W   = 3;
  localparam int RES_CNT_W   = 4;
  localparam int NUM_BYTES   = 8;
  localparam int COUNT_W     = 5;
  localparam int TIMER_W     = 16;
  localparam int ID_W        = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_NEXT  = 2'd2
  } phase_t;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_FC     = 3'd1;
  localparam logic [2:0] KIND_FULL   = 3'd2;
  localparam logic [2:0] KIND_SHORT  = 3'd3;
  localparam logic [2:0] KIND_FAILED = 3'd4;

  localparam logic [3:0] PCI_SINGLE = 4'd0;
  localparam logic [3:0] PCI_FIRST  = 4'd1;
  localparam logic [3:0] PCI_CONSEC = 4'd2;

  localparam logic [7:0] OBD_MODE_VIN = 8'h49;
  localparam logic [7:0] OBD_PID_VIN  = 8'h02;

  localparam logic [CFG_IDX_W-1:0] REG_RESPONDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_WAIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_WAIT  = 2'd2;

  localparam logic [ID_W-1:0]    RESPONDER_RESET  = 11'd2024;
  localparam logic [TIMER_W-1:0] FIRST_WAIT_RESET = 16'd500;
  localparam logic [TIMER_W-1:0] NEXT_WAIT_RESET  = 16'd1000;

  typedef struct packed {
    logic [1:0]      command;
    logic [ID_W-1:0] frame_id;
    logic [7:0]      byte_0;
    logic [7:0]      byte_1;
    logic [7:0]      byte_2;
    logic [7:0]      byte_3;
    logic [7:0]      byte_4;
    logic [7:0]      byte_5;
    logic [7:0]      byte_6;
    logic [7:0]      byte_7;
  } item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         char_value;
    logic [COUNT_W-1:0] char_count;
    logic               last;
  } result_t;

  typedef struct packed {
    phase_t             phase;
    logic [3:0]         expected_sequence;
    logic [COUNT_W-1:0] emitted_count;
    logic [TIMER_W-1:0] wait_timer;
  } rx_state_t;

  typedef struct packed {
    logic [ID_W-1:0]    responder_id;
    logic [TIMER_W-1:0] first_wait_ticks;
    logic [TIMER_W-1:0] next_wait_ticks;
  } rx_cfg_t;

endpackage

// ===== src/vir_item_if.sv =====
interface vir_item_if import vir_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/vir_result_if.sv =====
interface vir_result_if import vir_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/vir_step.sv =====
module vir_step import vir_pkg::*; #(
  parameter int ID_LENGTH = 17
) (
  input  item_t     item,
  input  rx_state_t cur,
  input  rx_cfg_t   cfg,
  output rx_state_t nxt,
  output result_t   res [MAX_RESULTS],
  output logic [RES_CNT_W-1:0] num
);

  logic [7:0]           b [NUM_BYTES];
  logic [NUM_BYTES-1:0] take_mask;
  logic                 send_fc;
  logic                 fin;
  logic                 check_full;
  logic [3:0]           pci;
  logic [3:0]           low;
  logic [TIMER_W-1:0]   limit;
  logic [COUNT_W-1:0]   cnt;
  logic [RES_CNT_W-1:0] n;
  logic [RES_CNT_W-1:0] n_last;
  logic [2:0]           fin_kind;

  localparam logic [COUNT_W-1:0] IdMax = COUNT_W'(ID_LENGTH);

  always_comb begin
    b[0] = item.byte_0;
    b[1] = item.byte_1;
    b[2] = item.byte_2;
    b[3] = item.byte_3;
    b[4] = item.byte_4;
    b[5] = item.byte_5;
    b[6] = item.byte_6;
    b[7] = item.byte_7;

    nxt        = cur;
    take_mask  = '0;
    send_fc    = 1'b0;
    fin        = 1'b0;
    check_full = 1'b0;
    pci        = b[0][7:4];
    low        = b[0][3:0];
    limit      = (cur.phase == PH_FIRST) ? cfg.first_wait_ticks : cfg.next_wait_ticks;

    case (item.command)
      CMD_START: begin
        nxt.phase             = PH_FIRST;
        nxt.wait_timer        = '0;
        nxt.emitted_count     = '0;
        nxt.expected_sequence = 4'd1;
      end
      CMD_TICK: begin
        if (cur.phase == PH_FIRST || cur.phase == PH_NEXT) begin
          if (cur.wait_timer >= limit) begin
            fin = 1'b1;
          end else begin
            nxt.wait_timer = cur.wait_timer + 1'b1;
          end
        end
      end
      CMD_FRAME: begin
        if (item.frame_id == cfg.responder_id) begin
          if (cur.phase == PH_FIRST) begin
            if (pci == PCI_SINGLE && b[1] == OBD_MODE_VIN) begin
              fin = 1'b1;
              if (b[2] == OBD_PID_VIN) begin
                // single frame carries characters in byte 4 up to byte <length>
                for (int i = 4; i < NUM_BYTES; i++) begin
                  take_mask[i] = (4'(i) <= low);
                end
              end
            end else if (pci == PCI_FIRST && b[2] == OBD_MODE_VIN) begin
              if (b[3] != OBD_PID_VIN) begin
                fin = 1'b1;
              end else begin
                take_mask[7:5]        = '1;
                send_fc               = 1'b1;
                check_full            = 1'b1;
                nxt.expected_sequence = 4'd1;
                nxt.wait_timer        = '0;
                nxt.phase             = PH_NEXT;
              end
            end
          end else if (cur.phase == PH_NEXT) begin
            if (pci == PCI_CONSEC && low == cur.expected_sequence) begin
              take_mask[7:1]        = '1;
              check_full            = 1'b1;
              nxt.expected_sequence = cur.expected_sequence + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // pack the results of this item in order: characters, flow control, final status
    cnt    = nxt.emitted_count;
    n      = '0;
    n_last = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    for (int i = 0; i < NUM_BYTES; i++) begin
      if (take_mask[i] && b[i] != 8'd0 && cnt < IdMax) begin
        cnt = cnt + 1'b1;
        res[n[RES_IDX_W-1:0]] = '{kind: KIND_CHAR, char_value: b[i], char_count: cnt,
                                  last: 1'b0};
        n = n + 1'b1;
      end
    end
    nxt.emitted_count = cnt;

    if (send_fc) begin
      res[n[RES_IDX_W-1:0]] = '{kind: KIND_FC, char_value: 8'd0, char_count: cnt,
                                last: 1'b0};
      n = n + 1'b1;
    end

    if (cnt >= IdMax) begin
      fin_kind = KIND_FULL;
    end else if (cnt != '0) begin
      fin_kind = KIND_SHORT;
    end else begin
      fin_kind = KIND_FAILED;
    end

    if (fin || (check_full && cnt >= IdMax)) begin
      nxt.phase = PH_IDLE;
      res[n[RES_IDX_W-1:0]] = '{kind: fin_kind, char_value: 8'd0, char_count: cnt,
                                last: 1'b0};
      n = n + 1'b1;
    end

    if (n != '0) begin
      n_last = n - 1'b1;
      res[n_last[RES_IDX_W-1:0]].last = 1'b1;
    end
    num = n;
  end

endmodule

// ===== src/vir_queue.sv =====
module vir_queue import vir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  result_t              load_res [MAX_RESULTS],
  input  logic [RES_CNT_W-1:0] load_num,
  output logic                 load_ok,
  vir_result_if.source         results
);

  result_t              entry [MAX_RESULTS];
  logic [RES_CNT_W-1:0] num;
  logic [RES_CNT_W-1:0] rd;
  result_t              out_q;
  logic                 out_valid;
  logic                 pending;
  logic                 move;

  assign pending = (rd != num);
  assign move    = pending && (!out_valid || results.ready);
  // a new batch may load in the cycle the last pending word leaves
  assign load_ok = !pending || (move && (rd + 1'b1 == num));

  always_ff @(posedge clk) begin
    if (rst) begin
      num       <= '0;
      rd        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        num <= load_num;
        rd  <= '0;
      end else if (move) begin
        rd <= rd + 1'b1;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_q <= entry[rd[RES_IDX_W-1:0]];
    end
    if (load) begin
      entry <= load_res;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_q;

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst) rd <= num)
    else $error("read pointer past batch size");
  a_num_in_range: assert property (@(posedge clk) disable iff (rst)
    num <= RES_CNT_W'(MAX_RESULTS))
    else $error("batch size too large");
  a_move_shows: assert property (@(posedge clk) disable iff (rst) move |=> results.valid)
    else $error("moved word not presented");
  a_load_safe: assert property (@(posedge clk) disable iff (rst) load |-> load_ok)
    else $error("batch loaded over pending words");

endmodule

// ===== src/vin_isotp_receiver_unit.sv =====
// Vehicle identification receiver over ISO-TP, mode 0x49 PID 0x02.
// frames: input words (start command, received CAN frame or millisecond tick).
// results: output words (character, flow-control request, done full/short, failed);
//   last marks the final word caused by one input word.
// cfg_we/cfg_index/cfg_data write responder id, first wait and next wait limits;
//   write only while the block is idle.
// An accepted word is held in an input register and decoded combinationally into
//   a batch of up to 8 results, which loads into the result queue when it has room.
// Throughput: one word per cycle for words with no result once the queue is empty;
//   otherwise one result word per cycle while results.ready is high, and the next
//   word's batch loads as the last result of the previous batch leaves.
// Reset: idle phase, counters cleared, registers back to id 2024, 500 and 1000 ticks.
// When the result side stalls, the output register and queue hold; after the queue
//   and input register fill, frames.ready drops until words drain.
module vin_isotp_receiver_unit import vir_pkg::*; #(
  parameter int ID_LENGTH = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  vir_item_if.sink              frames,
  vir_result_if.source          results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t                item_q;
  logic                 item_valid;
  logic                 take;
  logic                 load_ok;
  rx_state_t            st;
  rx_state_t            st_next;
  rx_cfg_t              cfg;
  result_t              batch [MAX_RESULTS];
  logic [RES_CNT_W-1:0] batch_num;

  assign take         = item_valid && load_ok;
  assign frames.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (frames.valid && frames.ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frames.valid && frames.ready) begin
      item_q <= frames.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase             <= PH_IDLE;
      st.expected_sequence <= '0;
      st.emitted_count     <= '0;
      st.wait_timer        <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.responder_id     <= RESPONDER_RESET;
      cfg.first_wait_ticks <= FIRST_WAIT_RESET;
      cfg.next_wait_ticks  <= NEXT_WAIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESPONDER:  cfg.responder_id     <= cfg_data[ID_W-1:0];
        REG_FIRST_WAIT: cfg.first_wait_ticks <= cfg_data[TIMER_W-1:0];
        REG_NEXT_WAIT:  cfg.next_wait_ticks  <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  vir_step #(
    .ID_LENGTH(ID_LENGTH)
  ) u_step (
    .item (item_q),
    .cur  (st),
    .cfg  (cfg),
    .nxt  (st_next),
    .res  (batch),
    .num  (batch_num)
  );

  vir_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .load_res (batch),
    .load_num (batch_num),
    .load_ok  (load_ok),
    .results  (results)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st.emitted_count <= COUNT_W'(ID_LENGTH))
    else $error("emitted count beyond identifier length");

endmodule
